// ===== hdl/f2h_pkg.sv =====
// f2h_pkg: shared constants and conversion functions for the fp32/fp16 converter
// no dependencies
package f2h_pkg;

    localparam logic [15:0] SGN16    = 16'h8000;
    localparam logic [22:0] MANT32   = 23'h7FFFFF;
    localparam logic [23:0] HIDDEN32 = 24'h800000;
    localparam logic [15:0] INF16    = 16'h7C00;
    localparam logic [15:0] QUIET16  = 16'h0200;
    localparam logic [9:0]  MANT16   = 10'h3FF;
    localparam logic [10:0] HIDDEN16 = 11'h400;
    localparam logic [31:0] EXP32    = 32'h7F800000;
    localparam logic        OP_NARROW = 1'b0;
    localparam logic        OP_WIDEN  = 1'b1;

    // single to half, truncating
    function automatic logic [15:0] narrow(input logic [31:0] v);
        logic [15:0] sign;
        logic [7:0]  e8;
        logic [22:0] mant;
        logic [23:0] full;
        logic [3:0]  sh;
        logic [23:0] shifted;
        sign = v[31] ? SGN16 : 16'h0000;
        e8 = v[30:23];
        mant = v[22:0] & MANT32;
        full = HIDDEN32 | {1'b0, mant};
        sh = 4'(8'd113 - e8);
        shifted = full >> sh;
        if (e8 == 8'hFF) begin
            narrow = sign | INF16 | ((mant != 23'd0) ? QUIET16 : 16'h0000);
        end else if (e8 >= 8'd143) begin
            narrow = sign | INF16;
        end else if (e8 <= 8'd112) begin
            if (e8 < 8'd102) begin
                narrow = sign;
            end else begin
                narrow = sign | {6'd0, shifted[22:13]};
            end
        end else begin
            narrow = sign | {1'b0, 5'(e8 - 8'd112), mant[22:13]};
        end
    endfunction

    // count of leading zeros in a 10-bit subnormal mantissa, plus one
    function automatic logic [3:0] sub_shift(input logic [9:0] m);
        logic [3:0] s;
        s = 4'd10;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                s = 4'(10 - i);
            end
        end
        sub_shift = s;
    endfunction

    // half to single, exact
    function automatic logic [31:0] widen(input logic [15:0] h);
        logic [31:0] sign;
        logic [4:0]  e5;
        logic [9:0]  mant;
        logic [3:0]  s;
        logic [10:0] norm;
        sign = {h[15], 31'd0};
        e5 = h[14:10];
        mant = h[9:0] & MANT16;
        s = sub_shift(mant);
        norm = {1'b0, mant} << s;
        if (e5 == 5'd0) begin
            if (mant == 10'd0) begin
                widen = sign;
            end else begin
                widen = sign | {1'b0, 8'(8'd113 - {4'd0, s}), norm[9:0], 13'd0};
            end
        end else if (e5 == 5'd31) begin
            widen = sign | EXP32 | {9'd0, mant, 13'd0};
        end else begin
            widen = sign | {1'b0, 8'({3'd0, e5} + 8'd112), mant, 13'd0};
        end
    endfunction

endpackage

// ===== hdl/f2h_core.sv =====
// f2h_core: combinational conversion datapath
// depends on f2h_pkg
module f2h_core (
    input  logic        i_op,
    input  logic [31:0] i_value,
    output logic [31:0] o_result
);
    always_comb begin
        case (i_op)
            f2h_pkg::OP_NARROW: o_result = {16'd0, f2h_pkg::narrow(i_value)};
            default:            o_result = f2h_pkg::widen(i_value[15:0]);
        endcase
    end
endmodule

// ===== hdl/fp32_fp16_converter_unit.sv =====
// fp32_fp16_converter_unit: top level of the single/half float converter
// depends on f2h_pkg and f2h_core
//
// usage:
//   a word is taken when start is high while busy is low; busy is always low
//   here, so a new word can be given every cycle
//   i_op 0 narrows the single in i_value to a half (result bits 15..0, upper
//   zero); i_op 1 widens the half in i_value[15:0] to a single
//   narrowing truncates; tiny values go subnormal then signed zero; finite
//   overflow gives signed infinity; nan becomes quiet nan with its sign
// pipeline and throughput:
//   the word is registered at the input, converted by one combinational
//   pass, and registered again; o_valid follows the accept through r_in_vld and r_out_vld
//   one word per cycle sustained, set by the single pass through f2h_core
// reset:
//   synchronous active-low reset clears the valid pipeline; payload is not reset
// output:
//   each result shows for exactly one cycle with o_valid; the receiver
//   cannot stall, so no buffering is needed
module fp32_fp16_converter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [31:0] i_value,
    output logic        o_valid,
    output logic [31:0] o_result
);
    // input stage
    logic        r_in_vld;
    logic        r_op;
    logic [31:0] r_value;
    // output stage
    logic        r_out_vld;
    logic [31:0] r_result;
    logic [31:0] n_result;

    assign busy = 1'b0;

    f2h_core u_core (
        .i_op     (r_op),
        .i_value  (r_value),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start;
            r_out_vld <= r_in_vld;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_op     <= i_op;
        r_value  <= i_value;
        r_result <= n_result;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_result;
endmodule

// ===== hdl/f2h_checker.sv =====
// f2h_checker: port-level assertions for the converter, bound to the top level
// depends on fp32_fp16_converter_unit
module f2h_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_op,
    input logic [31:0] i_value,
    input logic        o_valid,
    input logic [31:0] o_result
);
    // every accepted word yields a result once it has passed the input and output stages
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid) else $error("missing result");
    // no result without an accept
    a_noinv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2)) else $error("spurious result");
    // narrowing leaves upper bits zero
    a_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == 1'b0) |=> ##1 (o_result[31:16] == 16'd0))
        else $error("upper bits set on narrow");
    // single nan narrows to quiet nan
    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == 1'b0 && i_value[30:23] == 8'hFF && i_value[22:0] != 23'd0)
        |=> ##1 (o_result[14:0] == 15'h7E00)) else $error("nan not quiet");
endmodule

bind fp32_fp16_converter_unit f2h_checker u_f2h_checker (.*);
